>>> hw/rtl/bbsf_pkg.sv
// Shared types and constants for the bounded byte stream FIFO.
// Holds the operation codes, the field widths and the result layout.
// No dependencies; imported by every module of the block.
package bbsf_pkg;

  localparam int BYTE_W  = 8;
  localparam int FUNC_W  = 2;
  localparam int LEVEL_W = 11;
  localparam int TOTAL_W = 32;

  // Result record, first field in the lowest bits
  localparam int RES_W   = 2 + BYTE_W + 2 * LEVEL_W + 2 * TOTAL_W + 2;
  localparam int OUT_W   = ((RES_W + 7) / 8) * 8;

  // Operation codes carried on in_tuser
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_END   = 2'd3;

  localparam logic [LEVEL_W-1:0] CAP_RESET = 11'd1024;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [TOTAL_W-1:0] total_t;

  // Result fields except the byte, which comes from the store's registered read port
  typedef struct packed {
    logic   at_eof;
    logic   ended;
    total_t total_read;
    total_t total_written;
    level_t room_left;
    level_t fill_level;
    logic   read_valid;
    logic   write_accepted;
  } status_t;

endpackage

>>> hw/rtl/bbsf_store.sv
// Byte storage of the FIFO: one write port and one registered read port.
// Depends on bbsf_pkg for the byte type.
// Read data holds while no read is issued.
module bbsf_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  bbsf_pkg::byte_t wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output bbsf_pkg::byte_t rd_data
);
  import bbsf_pkg::*;

  byte_t mem [DEPTH];
  byte_t rd_data_r;

  // Write one byte at the tail
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read the head; the register keeps the byte through output stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/bounded_byte_stream_fifo_unit.sv
// Top level of the bounded byte stream FIFO: control, pointers, totals, result stage.
// Depends on bbsf_pkg and instantiates bbsf_store for the byte memory.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+-----------------------------------------
//   in_     | in  | in_tvalid / in_tready  | tuser: func; tdata: data_byte
//   out_    | out | out_tvalid / out_tready| tdata: result fields, see port comment
//   cfg_    | in  | cfg_valid / cfg_ready  | cfg_data: stream_capacity
//
// One item per clock while the result channel does not stall; each item gives its
// result in the cycle after its transfer, with the byte from the registered read port.
// Reset (rst_n low, synchronous) empties the FIFO, clears totals and the ended flag
// and sets the capacity to 1024; the byte store itself is not cleared.
// A held result stalls the input; the configuration port is always ready.
module bounded_byte_stream_fifo_unit #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] data_byte
  input  logic [bbsf_pkg::FUNC_W-1:0]   in_tuser,   // [1:0] func
  // Result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] write_accepted, [1] read_valid, [9:2] read_byte, [20:10] fill_level,
  // [31:21] room_left, [63:32] total_written, [95:64] total_read,
  // [96] ended, [97] at_eof, [103:98] zero
  output logic [bbsf_pkg::OUT_W-1:0]    out_tdata,
  // Configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bbsf_pkg::LEVEL_W-1:0]  cfg_data    // stream_capacity
);
  import bbsf_pkg::*;

  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int CMPW   = (LEVEL_W > $clog2(STORE_DEPTH + 1)) ? LEVEL_W
                                                             : $clog2(STORE_DEPTH + 1);
  localparam logic [CMPW-1:0] DEPTH_CMP = CMPW'(STORE_DEPTH);
  localparam logic [AW-1:0]   LAST_IDX  = AW'(STORE_DEPTH - 1);

  // State
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  level_t        count_r, count_nxt;
  total_t        wr_total_r, wr_total_nxt;
  total_t        rd_total_r, rd_total_nxt;
  logic          ended_r, ended_nxt;
  level_t        cap_r;

  // Result stage
  logic          out_valid_r;
  status_t       status_r, status_nxt;
  logic          rd_pending_r;

  // Per-item decode
  logic          in_xfer;
  logic [FUNC_W-1:0] func;
  byte_t         data_byte;
  level_t        cap_eff;
  logic          do_write;
  logic          do_read;
  logic          do_pop;
  byte_t         rd_byte;

  assign func      = in_tuser;
  assign data_byte = in_tdata[BYTE_W-1:0];
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Clamp the capacity register to the store depth
  always_comb begin
    if (CMPW'(cap_r) > DEPTH_CMP) begin
      cap_eff = DEPTH_CMP[LEVEL_W-1:0];
    end else begin
      cap_eff = cap_r;
    end
  end

  // Decide the item's effect and the next state
  always_comb begin
    do_write     = 1'b0;
    do_read      = 1'b0;
    do_pop       = 1'b0;
    ended_nxt    = ended_r;
    unique case (func)
      FUNC_WRITE: do_write  = !ended_r && (count_r < cap_eff);
      FUNC_POP: begin
        do_read = (count_r != '0);
        do_pop  = (count_r != '0);
      end
      FUNC_PEEK:  do_read   = (count_r != '0);
      FUNC_END:   ended_nxt = 1'b1;
      default:    ended_nxt = ended_r;
    endcase

    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    wr_total_nxt = wr_total_r;
    rd_total_nxt = rd_total_r;
    if (do_write) begin
      tail_nxt     = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
      count_nxt    = count_r + 1'b1;
      wr_total_nxt = wr_total_r + 1'b1;
    end
    if (do_pop) begin
      head_nxt     = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
      count_nxt    = count_r - 1'b1;
      rd_total_nxt = rd_total_r + 1'b1;
    end

    status_nxt.write_accepted = do_write;
    status_nxt.read_valid     = do_read;
    status_nxt.fill_level     = count_nxt;
    status_nxt.room_left      = (cap_eff > count_nxt) ? cap_eff - count_nxt : '0;
    status_nxt.total_written  = wr_total_nxt;
    status_nxt.total_read     = rd_total_nxt;
    status_nxt.ended          = ended_nxt;
    status_nxt.at_eof         = ended_nxt && (count_nxt == '0);
  end

  // Advance FIFO state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      wr_total_r <= '0;
      rd_total_r <= '0;
      ended_r    <= 1'b0;
    end else if (in_xfer) begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      wr_total_r <= wr_total_nxt;
      rd_total_r <= rd_total_nxt;
      ended_r    <= ended_nxt;
    end
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // Result stage: load on transfer, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r     <= status_nxt;
      rd_pending_r <= do_read;
    end
  end

  // Byte memory; head and tail never meet on a same-cycle read and write
  bbsf_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_xfer && do_write),
    .wr_addr (tail_r),
    .wr_data (data_byte),
    .rd_en   (in_xfer && do_read),
    .rd_addr (head_r),
    .rd_data (rd_byte)
  );

  // Pack the result
  always_comb begin
    out_tdata          = '0;
    out_tdata[0]       = status_r.write_accepted;
    out_tdata[1]       = status_r.read_valid;
    out_tdata[9:2]     = rd_pending_r ? rd_byte : '0;
    out_tdata[20:10]   = status_r.fill_level;
    out_tdata[31:21]   = status_r.room_left;
    out_tdata[63:32]   = status_r.total_written;
    out_tdata[95:64]   = status_r.total_read;
    out_tdata[96]      = status_r.ended;
    out_tdata[97]      = status_r.at_eof;
  end

  assign out_tvalid = out_valid_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(count_r) <= DEPTH_CMP)
    else $error("fill count exceeds store depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty FIFO with head and tail apart");

  a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |=> ended_r)
    else $error("ended flag cleared without reset");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(status_r.write_accepted && status_r.read_valid))
    else $error("result both wrote and read");

endmodule
